// ===== design/masked_hamming_distance_macros.svh =====
// Assertion macros for the masked Hamming distance block.
`ifndef MASKED_HAMMING_DISTANCE_MACROS_SVH
`define MASKED_HAMMING_DISTANCE_MACROS_SVH
`ifndef SYNTHESIS
`define MHD_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("masked_hamming_distance: assertion failed");
`define MHD_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("masked_hamming_distance: assertion failed");
`else
`define MHD_ASSERT_IMP(label, cond, expr)
`define MHD_ASSERT_NXT(label, cond, expr)
`endif
`endif

// ===== design/mhd_pkg.sv =====
// Shared constants, types and the saturating add function of the masked Hamming distance block.
package mhd_pkg;

    localparam int DESC_BYTES = 64;
    localparam int DESC_BITS  = DESC_BYTES * 8;
    localparam int COUNT_W    = 10;
    localparam int COUNT_MAX  = (DESC_BITS < 1023) ? DESC_BITS : 1023;
    localparam int CHUNK_W    = 64;
    localparam int LANE_W     = 8;
    localparam int LANES      = CHUNK_W / LANE_W;
    localparam int LCNT_W     = $clog2(LANE_W + 1);
    localparam int SUM_W      = $clog2(CHUNK_W + 1);
    localparam int DIST_W     = COUNT_W;
    localparam int PROD_W     = 2 * COUNT_W;
    localparam int NUM_W      = PROD_W + 1;
    localparam int DEN_W      = COUNT_W + 1;
    localparam int ITER_W     = $clog2(NUM_W);

    typedef struct packed {
        logic [LCNT_W-1:0] diff_a;
        logic [LCNT_W-1:0] diff_b;
        logic [LCNT_W-1:0] ones_a;
        logic [LCNT_W-1:0] ones_b;
        logic [LCNT_W-1:0] diff;
    } lane_cnt_t;

    typedef struct packed {
        logic [COUNT_W-1:0] diff_a;
        logic [COUNT_W-1:0] diff_b;
        logic [COUNT_W-1:0] ones_a;
        logic [COUNT_W-1:0] ones_b;
        logic [COUNT_W-1:0] diff;
        logic               masked;
    } pair_cnt_t;

    typedef enum logic [2:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_SUM,
        DIV_ITER,
        DIV_DONE
    } div_state_t;

    function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] acc,
                                                   input logic [SUM_W-1:0]   add);
        logic [COUNT_W:0] s;
        s = {1'b0, acc} + {{(COUNT_W + 1 - SUM_W){1'b0}}, add};
        if (s > (COUNT_W + 1)'(COUNT_MAX)) begin
            return COUNT_W'(COUNT_MAX);
        end
        return s[COUNT_W-1:0];
    endfunction

endpackage

// ===== design/mhd_lane.sv =====
// One byte lane: XOR the descriptors and count differing and mask bits.
module mhd_lane (
    input  logic [mhd_pkg::LANE_W-1:0] desc_a,
    input  logic [mhd_pkg::LANE_W-1:0] mask_a,
    input  logic [mhd_pkg::LANE_W-1:0] desc_b,
    input  logic [mhd_pkg::LANE_W-1:0] mask_b,
    output mhd_pkg::lane_cnt_t         cnt
);

    logic [mhd_pkg::LANE_W-1:0] diff;

    assign diff = desc_a ^ desc_b;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < mhd_pkg::LANE_W; i++) begin
            cnt.diff_a = cnt.diff_a + mhd_pkg::LCNT_W'(diff[i] & mask_a[i]);
            cnt.diff_b = cnt.diff_b + mhd_pkg::LCNT_W'(diff[i] & mask_b[i]);
            cnt.ones_a = cnt.ones_a + mhd_pkg::LCNT_W'(mask_a[i]);
            cnt.ones_b = cnt.ones_b + mhd_pkg::LCNT_W'(mask_b[i]);
            cnt.diff   = cnt.diff   + mhd_pkg::LCNT_W'(diff[i]);
        end
    end

endmodule

// ===== design/mhd_merge.sv =====
// Merge the lane counts of a chunk and keep the saturating per-pair totals.
module mhd_merge (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    lane_valid,
    input  logic                    lane_last,
    input  mhd_pkg::lane_cnt_t      lane_cnt [mhd_pkg::LANES],
    input  logic                    masked_mode,
    output logic                    snap_valid,
    output mhd_pkg::pair_cnt_t      snap
);

    logic [mhd_pkg::SUM_W-1:0]   sum_diff_a, sum_diff_b, sum_ones_a, sum_ones_b, sum_diff;
    logic [mhd_pkg::COUNT_W-1:0] acc_diff_a_reg, acc_diff_b_reg, acc_ones_a_reg;
    logic [mhd_pkg::COUNT_W-1:0] acc_ones_b_reg, acc_diff_reg;
    mhd_pkg::pair_cnt_t          total;
    mhd_pkg::pair_cnt_t          snap_reg;
    logic                        snap_valid_reg;

    always_comb begin
        sum_diff_a = '0;
        sum_diff_b = '0;
        sum_ones_a = '0;
        sum_ones_b = '0;
        sum_diff   = '0;
        for (int i = 0; i < mhd_pkg::LANES; i++) begin
            sum_diff_a = sum_diff_a + mhd_pkg::SUM_W'(lane_cnt[i].diff_a);
            sum_diff_b = sum_diff_b + mhd_pkg::SUM_W'(lane_cnt[i].diff_b);
            sum_ones_a = sum_ones_a + mhd_pkg::SUM_W'(lane_cnt[i].ones_a);
            sum_ones_b = sum_ones_b + mhd_pkg::SUM_W'(lane_cnt[i].ones_b);
            sum_diff   = sum_diff   + mhd_pkg::SUM_W'(lane_cnt[i].diff);
        end
    end

    always_comb begin
        total.diff_a = mhd_pkg::sat_add(acc_diff_a_reg, sum_diff_a);
        total.diff_b = mhd_pkg::sat_add(acc_diff_b_reg, sum_diff_b);
        total.ones_a = mhd_pkg::sat_add(acc_ones_a_reg, sum_ones_a);
        total.ones_b = mhd_pkg::sat_add(acc_ones_b_reg, sum_ones_b);
        total.diff   = mhd_pkg::sat_add(acc_diff_reg, sum_diff);
        total.masked = masked_mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_diff_a_reg <= '0;
            acc_diff_b_reg <= '0;
            acc_ones_a_reg <= '0;
            acc_ones_b_reg <= '0;
            acc_diff_reg   <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            snap_valid_reg <= lane_valid & lane_last;
            if (lane_valid) begin
                // clear the totals once the last chunk hands them off
                if (lane_last) begin
                    acc_diff_a_reg <= '0;
                    acc_diff_b_reg <= '0;
                    acc_ones_a_reg <= '0;
                    acc_ones_b_reg <= '0;
                    acc_diff_reg   <= '0;
                end else begin
                    acc_diff_a_reg <= total.diff_a;
                    acc_diff_b_reg <= total.diff_b;
                    acc_ones_a_reg <= total.ones_a;
                    acc_ones_b_reg <= total.ones_b;
                    acc_diff_reg   <= total.diff;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (lane_valid && lane_last) begin
            snap_reg <= total;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== design/mhd_div.sv =====
// Weighting, bit-serial division and the result register.
module mhd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         snap_valid,
    input  mhd_pkg::pair_cnt_t           snap,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [mhd_pkg::DIST_W-1:0]   m_distance,
    output logic                         m_no_valid_bits,
    output logic                         done
);

    mhd_pkg::div_state_t          state_reg, state_next;
    mhd_pkg::pair_cnt_t           cnt_reg, cnt_next;
    logic [mhd_pkg::PROD_W-1:0]   prod_a_reg, prod_a_next, prod_b_reg, prod_b_next;
    logic [mhd_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [mhd_pkg::DEN_W-1:0]    den_reg, den_next, rem_reg, rem_next;
    logic [mhd_pkg::ITER_W-1:0]   iter_reg, iter_next;
    logic                         m_valid_reg, m_valid_next;
    logic [mhd_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic                         flag_reg, flag_next;
    logic [mhd_pkg::DEN_W:0]      trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mhd_pkg::DIV_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        iter_reg   <= iter_next;
        dist_reg   <= dist_next;
        flag_reg   <= flag_next;
    end

    assign trial = {rem_reg, num_reg[mhd_pkg::NUM_W-1]};

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        prod_a_next  = prod_a_reg;
        prod_b_next  = prod_b_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        iter_next    = iter_reg;
        dist_next    = dist_reg;
        flag_next    = flag_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        done         = 1'b0;
        case (state_reg)
            mhd_pkg::DIV_IDLE: begin
                if (snap_valid) begin
                    cnt_next   = snap;
                    state_next = mhd_pkg::DIV_MUL;
                end
            end
            mhd_pkg::DIV_MUL: begin
                prod_a_next = mhd_pkg::PROD_W'(cnt_reg.diff_a) * mhd_pkg::PROD_W'(cnt_reg.ones_a);
                prod_b_next = mhd_pkg::PROD_W'(cnt_reg.diff_b) * mhd_pkg::PROD_W'(cnt_reg.ones_b);
                state_next  = mhd_pkg::DIV_SUM;
            end
            mhd_pkg::DIV_SUM: begin
                num_next  = {1'b0, prod_a_reg} + {1'b0, prod_b_reg};
                den_next  = {1'b0, cnt_reg.ones_a} + {1'b0, cnt_reg.ones_b};
                rem_next  = '0;
                iter_next = mhd_pkg::ITER_W'(mhd_pkg::NUM_W - 1);
                if (!cnt_reg.masked || den_next == '0) begin
                    state_next = mhd_pkg::DIV_DONE;
                end else begin
                    state_next = mhd_pkg::DIV_ITER;
                end
            end
            mhd_pkg::DIV_ITER: begin
                // restoring step: quotient bits shift into the numerator register
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = mhd_pkg::DEN_W'(trial - {1'b0, den_reg});
                    num_next = {num_reg[mhd_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[mhd_pkg::DEN_W-1:0];
                    num_next = {num_reg[mhd_pkg::NUM_W-2:0], 1'b0};
                end
                if (iter_reg == '0) begin
                    state_next = mhd_pkg::DIV_DONE;
                end else begin
                    iter_next = iter_reg - mhd_pkg::ITER_W'(1);
                end
            end
            mhd_pkg::DIV_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    done         = 1'b1;
                    state_next   = mhd_pkg::DIV_IDLE;
                    flag_next    = 1'b0;
                    if (!cnt_reg.masked) begin
                        dist_next = cnt_reg.diff;
                    end else if (den_reg == '0) begin
                        dist_next = '0;
                        flag_next = 1'b1;
                    end else if (|num_reg[mhd_pkg::NUM_W-1:mhd_pkg::DIST_W]) begin
                        dist_next = '1;
                    end else begin
                        dist_next = num_reg[mhd_pkg::DIST_W-1:0];
                    end
                end
            end
            default: begin
                state_next = mhd_pkg::DIV_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_distance      = dist_reg;
    assign m_no_valid_bits = flag_reg;

endmodule

// ===== design/masked_hamming_distance.sv =====
// Masked Hamming distance top level: lanes, merge, divider, config register.
// Chunks of a descriptor pair are taken one per cycle through eight byte lanes while s_ready is high.
// After the last chunk the counts pass the lane register, merge snapshot and multiply and sum
// states, then in masked mode with non-empty masks the 21-step bit-serial divider.
// s_ready stays low from the last chunk until its result is loaded into the output register.
// Synchronous active-low reset clears the counts and sets masked_mode to 1.
`include "masked_hamming_distance_macros.svh"

module masked_hamming_distance (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mhd_pkg::CHUNK_W-1:0]   s_desc_a_chunk,
    input  logic [mhd_pkg::CHUNK_W-1:0]   s_mask_a_chunk,
    input  logic [mhd_pkg::CHUNK_W-1:0]   s_desc_b_chunk,
    input  logic [mhd_pkg::CHUNK_W-1:0]   s_mask_b_chunk,
    input  logic                          s_last_chunk,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mhd_pkg::DIST_W-1:0]    m_distance,
    output logic                          m_no_valid_bits
);

    logic                masked_mode_reg;
    logic                pend_reg, pend_next;
    logic                accept;
    logic                lane_valid_reg, lane_last_reg;
    mhd_pkg::lane_cnt_t  lane_cnt     [mhd_pkg::LANES];
    mhd_pkg::lane_cnt_t  lane_cnt_reg [mhd_pkg::LANES];
    logic                snap_valid;
    mhd_pkg::pair_cnt_t  snap;
    logic                done;

    assign s_ready = ~pend_reg;
    assign accept  = s_valid & s_ready;

    for (genvar g = 0; g < mhd_pkg::LANES; g++) begin : g_lane
        mhd_lane u_lane (
            .desc_a (s_desc_a_chunk[g*mhd_pkg::LANE_W +: mhd_pkg::LANE_W]),
            .mask_a (s_mask_a_chunk[g*mhd_pkg::LANE_W +: mhd_pkg::LANE_W]),
            .desc_b (s_desc_b_chunk[g*mhd_pkg::LANE_W +: mhd_pkg::LANE_W]),
            .mask_b (s_mask_b_chunk[g*mhd_pkg::LANE_W +: mhd_pkg::LANE_W]),
            .cnt    (lane_cnt[g])
        );
    end

    // a pair stays pending from its last request until the result is loaded
    assign pend_next = (pend_reg | (accept & s_last_chunk)) & ~done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            masked_mode_reg <= 1'b1;
            pend_reg        <= 1'b0;
            lane_valid_reg  <= 1'b0;
            lane_last_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                masked_mode_reg <= cfg_wr_data;
            end
            pend_reg       <= pend_next;
            lane_valid_reg <= accept;
            lane_last_reg  <= accept & s_last_chunk;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            lane_cnt_reg <= lane_cnt;
        end
    end

    mhd_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .lane_valid  (lane_valid_reg),
        .lane_last   (lane_last_reg),
        .lane_cnt    (lane_cnt_reg),
        .masked_mode (masked_mode_reg),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    mhd_div u_div (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .snap_valid      (snap_valid),
        .snap            (snap),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_distance      (m_distance),
        .m_no_valid_bits (m_no_valid_bits),
        .done            (done)
    );

    `MHD_ASSERT_IMP(a_result_follows_pair, $rose(m_valid), $past(pend_reg))
    `MHD_ASSERT_IMP(a_empty_masks_zero, m_valid && m_no_valid_bits, m_distance == '0)
    `MHD_ASSERT_IMP(a_distance_bound, m_valid, m_distance <= mhd_pkg::COUNT_MAX)
    `MHD_ASSERT_NXT(a_no_request_while_pending, accept && s_last_chunk, !s_ready)

endmodule

// ===== verif/distance_checker.sv =====
// Scoreboard for the masked Hamming distance block: predicts each result and compares it.
`timescale 1ns / 1ps

module distance_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_wr_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [mhd_pkg::CHUNK_W-1:0] s_desc_a_chunk,
    input  logic [mhd_pkg::CHUNK_W-1:0] s_mask_a_chunk,
    input  logic [mhd_pkg::CHUNK_W-1:0] s_desc_b_chunk,
    input  logic [mhd_pkg::CHUNK_W-1:0] s_mask_b_chunk,
    input  logic                        s_last_chunk,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [mhd_pkg::DIST_W-1:0]  m_distance,
    input  logic                        m_no_valid_bits,
    output int                          fail_count,
    output int                          outstanding
);

    typedef struct packed {
        logic [mhd_pkg::DIST_W-1:0] distance;
        logic                       no_valid_bits;
    } dist_result_t;

    typedef struct packed {
        logic [mhd_pkg::COUNT_W-1:0] hits_a;
        logic [mhd_pkg::COUNT_W-1:0] hits_b;
        logic [mhd_pkg::COUNT_W-1:0] ones_a;
        logic [mhd_pkg::COUNT_W-1:0] ones_b;
        logic [mhd_pkg::COUNT_W-1:0] hits_all;
    } pair_tally_t;

    dist_result_t expected_distances[$];
    pair_tally_t  tally;
    logic         weighted_mode;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic [mhd_pkg::COUNT_W-1:0] bump(
            input logic [mhd_pkg::COUNT_W-1:0] acc,
            input int unsigned                 n);
        int unsigned s;
        s = acc + n;
        if (s > mhd_pkg::COUNT_MAX) begin
            s = mhd_pkg::COUNT_MAX;
        end
        return mhd_pkg::COUNT_W'(s);
    endfunction

    function automatic pair_tally_t tally_chunk(input pair_tally_t t,
                                                input logic [mhd_pkg::CHUNK_W-1:0] da,
                                                input logic [mhd_pkg::CHUNK_W-1:0] ma,
                                                input logic [mhd_pkg::CHUNK_W-1:0] db,
                                                input logic [mhd_pkg::CHUNK_W-1:0] mb);
        logic [mhd_pkg::CHUNK_W-1:0] flips;
        flips      = da ^ db;
        t.hits_a   = bump(t.hits_a, $countones(flips & ma));
        t.hits_b   = bump(t.hits_b, $countones(flips & mb));
        t.ones_a   = bump(t.ones_a, $countones(ma));
        t.ones_b   = bump(t.ones_b, $countones(mb));
        t.hits_all = bump(t.hits_all, $countones(flips));
        return t;
    endfunction

    // Weighted mean of the two masked counts, floored and saturated; plain count otherwise.
    function automatic dist_result_t pair_distance(input pair_tally_t t, input logic weighted);
        dist_result_t      r;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        r.no_valid_bits = 1'b0;
        r.distance      = t.hits_all;
        if (weighted) begin
            den = 64'(t.ones_a) + 64'(t.ones_b);
            if (den == 0) begin
                r.distance      = '0;
                r.no_valid_bits = 1'b1;
            end else begin
                num = 64'(t.hits_a) * 64'(t.ones_a) + 64'(t.hits_b) * 64'(t.ones_b);
                q   = num / den;
                if (q > (1 << mhd_pkg::DIST_W) - 1) begin
                    q = (1 << mhd_pkg::DIST_W) - 1;
                end
                r.distance = mhd_pkg::DIST_W'(q);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin : scoreboard
        dist_result_t want;
        if (!aresetn) begin
            tally         = '0;
            weighted_mode = 1'b1;
            expected_distances.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_distances.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, distance %0d", m_distance));
                end else begin
                    want = expected_distances.pop_front();
                    if (m_distance !== want.distance) begin
                        report_mismatch($sformatf("distance %0d, expected %0d",
                                                  m_distance, want.distance));
                    end
                    if (m_no_valid_bits !== want.no_valid_bits) begin
                        report_mismatch($sformatf("no_valid_bits %0b, expected %0b",
                                                  m_no_valid_bits, want.no_valid_bits));
                    end
                end
            end
            if (s_valid && s_ready) begin
                tally = tally_chunk(tally, s_desc_a_chunk, s_mask_a_chunk,
                                    s_desc_b_chunk, s_mask_b_chunk);
                // The mode in force on the last chunk decides the result.
                if (s_last_chunk) begin
                    expected_distances = {expected_distances,
                                          pair_distance(tally, weighted_mode)};
                    tally = '0;
                end
            end
            if (cfg_wr_en) begin
                weighted_mode = cfg_wr_data;
            end
        end
        outstanding = expected_distances.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the masked Hamming distance block: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 32;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int RANDOM_CHUNKS  = 1750;
    localparam int PHASES         = 6;
    localparam int SQUEEZE_AFTER  = 600;
    localparam int SQUEEZE_CYCLES = 500;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic                        cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [mhd_pkg::CHUNK_W-1:0] s_desc_a_chunk;
    logic [mhd_pkg::CHUNK_W-1:0] s_mask_a_chunk;
    logic [mhd_pkg::CHUNK_W-1:0] s_desc_b_chunk;
    logic [mhd_pkg::CHUNK_W-1:0] s_mask_b_chunk;
    logic                        s_last_chunk;
    logic                        m_valid;
    logic                        m_ready;
    logic [mhd_pkg::DIST_W-1:0]  m_distance;
    logic                        m_no_valid_bits;
    int                          fail_count;
    int                          outstanding;

    int chunks_sent = 0;
    bit in_random   = 1'b0;
    bit squeezed    = 1'b0;
    bit no_gap_run  = 1'b0;
    bit eager       = 1'b0;

    masked_hamming_distance i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_desc_a_chunk  (s_desc_a_chunk),
        .s_mask_a_chunk  (s_mask_a_chunk),
        .s_desc_b_chunk  (s_desc_b_chunk),
        .s_mask_b_chunk  (s_mask_b_chunk),
        .s_last_chunk    (s_last_chunk),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_distance      (m_distance),
        .m_no_valid_bits (m_no_valid_bits)
    );

    distance_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_desc_a_chunk  (s_desc_a_chunk),
        .s_mask_a_chunk  (s_mask_a_chunk),
        .s_desc_b_chunk  (s_desc_b_chunk),
        .s_mask_b_chunk  (s_mask_b_chunk),
        .s_last_chunk    (s_last_chunk),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_distance      (m_distance),
        .m_no_valid_bits (m_no_valid_bits),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF) aclk = ~aclk;

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [mhd_pkg::CHUNK_W-1:0] pick_word();
        logic [mhd_pkg::CHUNK_W-1:0] w;
        int unsigned                 pos;
        w   = {$urandom, $urandom};
        pos = $urandom_range(0, mhd_pkg::CHUNK_W - 1);
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = mhd_pkg::CHUNK_W'(1) << pos;
            3: w = ~(mhd_pkg::CHUNK_W'(1) << pos);
            default: ;
        endcase
        return w;
    endfunction

    function automatic int pick_pair_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return $urandom_range(1, 8);
        end else if (r < 9) begin
            return mhd_pkg::DESC_BYTES / 8;
        end
        return $urandom_range(mhd_pkg::DESC_BYTES / 8 + 1, mhd_pkg::DESC_BYTES / 8 + 4);
    endfunction

    task automatic send_chunk(input logic [mhd_pkg::CHUNK_W-1:0] da,
                              input logic [mhd_pkg::CHUNK_W-1:0] ma,
                              input logic [mhd_pkg::CHUNK_W-1:0] db,
                              input logic [mhd_pkg::CHUNK_W-1:0] mb,
                              input logic last);
        int gap;
        gap = no_gap_run ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_desc_a_chunk <= da;
        s_mask_a_chunk <= ma;
        s_desc_b_chunk <= db;
        s_mask_b_chunk <= mb;
        s_last_chunk   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chunks_sent++;
    endtask

    task automatic send_pair(input int n_chunks);
        int                          mask_style;
        logic [mhd_pkg::CHUNK_W-1:0] da;
        logic [mhd_pkg::CHUNK_W-1:0] ma;
        logic [mhd_pkg::CHUNK_W-1:0] db;
        logic [mhd_pkg::CHUNK_W-1:0] mb;
        mask_style = $urandom_range(0, 9);
        for (int i = 0; i < n_chunks; i++) begin
            da = pick_word();
            ma = pick_word();
            mb = pick_word();
            case ($urandom_range(0, 7))
                0: db = da;
                1: db = ~da;
                default: db = pick_word();
            endcase
            case (mask_style)
                0: begin
                    ma = '0;
                    mb = '0;
                end
                1: ma = '0;
                2: mb = '0;
                3: begin
                    ma = '1;
                    mb = '1;
                end
                default: ;
            endcase
            send_chunk(da, ma, db, mb, i == n_chunks - 1);
        end
    endtask

    // Write the mode only once every pending request has drained out.
    task automatic set_mode(input logic weighted);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= weighted;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge aclk);
        $display("tb failed");
        $finish;
    end

    initial begin : receiver
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            // Hold off long enough for requests to back up into the input.
            if (in_random && !squeezed && chunks_sent > SQUEEZE_AFTER) begin
                squeezed = 1'b1;
                m_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 199) == 0) begin
                eager = !eager;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!eager) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : stimulus
        int phase_start;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_valid        = 1'b0;
        s_desc_a_chunk = '0;
        s_mask_a_chunk = '0;
        s_desc_b_chunk = '0;
        s_mask_b_chunk = '0;
        s_last_chunk   = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Weighted mode out of reset: empty masks, full masks, half mask, then a random full-length pair.
        send_chunk('0, '0, '0, '0, 1'b1);
        send_chunk('1, '1, '0, '1, 1'b1);
        send_chunk('1, 64'h0000_0000_FFFF_FFFF, '0, '1, 1'b1);
        for (int i = 0; i < mhd_pkg::DESC_BYTES / 8; i++) begin
            send_chunk(pick_word(), pick_word(), pick_word(), pick_word(),
                       i == mhd_pkg::DESC_BYTES / 8 - 1);
        end
        // Run past the descriptor length so every count saturates.
        for (int i = 0; i <= mhd_pkg::DESC_BYTES / 8; i++) begin
            send_chunk('1, '1, '0, '1, i == mhd_pkg::DESC_BYTES / 8);
        end
        // Switch to plain mode between chunks of one pair.
        send_chunk(pick_word(), pick_word(), pick_word(), pick_word(), 1'b0);
        send_chunk(pick_word(), pick_word(), pick_word(), pick_word(), 1'b0);
        set_mode(1'b0);
        send_chunk(pick_word(), pick_word(), pick_word(), pick_word(), 1'b1);
        send_chunk('1, '0, '0, '0, 1'b1);
        set_mode(1'b1);

        in_random = 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            set_mode(phase % 2 == 1);
            phase_start = chunks_sent;
            while (chunks_sent - phase_start < RANDOM_CHUNKS / PHASES) begin
                if ($urandom_range(0, 9) == 0) begin
                    no_gap_run = !no_gap_run;
                end
                send_pair(pick_pair_length());
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/mhd_pkg.sv
design/mhd_lane.sv
design/mhd_merge.sv
design/mhd_div.sv
design/masked_hamming_distance.sv
verif/distance_checker.sv
verif/tb.sv
